// ===== hw/rtl/ubx_frame_parser_core_macros.svh =====
// Assertion macros used by the UBX frame parser RTL (the emitter).
`ifndef UBX_FRAME_PARSER_CORE_MACROS_SVH
`define UBX_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBX_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UBX_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ubx_pkg.sv =====
// Types, constants and helper functions for the UBX frame parser.
`default_nettype none
package ubx_pkg;

  localparam int PAYLOAD_MAX_DEF = 96;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLS_ACK     = 8'h05;
  localparam logic [7:0] CLS_NAV     = 8'h01;
  localparam logic [7:0] ID_ACKOK    = 8'h01;
  localparam logic [7:0] ID_PVT      = 8'h07;
  localparam logic [15:0] ACK_LEN    = 16'd2;
  localparam logic [15:0] PVT_LEN    = 16'd72;
  localparam logic [3:0] PVT_LAST_WORD = 4'd12;
  localparam logic [3:0] PVT_PACKED_WORD = 4'd1;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_NAK   = 2'd1,
    KIND_PVT   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_FETCH,
    EM_OUT
  } emit_state_t;

  typedef struct packed {
    logic        start;
    kind_t       kind;
    logic [15:0] other_val;
  } emit_req_t;

  function automatic logic [6:0] pvt_offset(input logic [3:0] word);
    logic [6:0] off;
    begin
      case (word)
        4'd0:    off = 7'd0;
        4'd1:    off = 7'd20;
        4'd2:    off = 7'd24;
        4'd3:    off = 7'd28;
        4'd4:    off = 7'd36;
        4'd5:    off = 7'd40;
        4'd6:    off = 7'd44;
        4'd7:    off = 7'd48;
        4'd8:    off = 7'd52;
        4'd9:    off = 7'd56;
        4'd10:   off = 7'd60;
        4'd11:   off = 7'd64;
        4'd12:   off = 7'd68;
        default: off = 7'd0;
      endcase
      return off;
    end
  endfunction

  // Payload byte address for byte j of the current result word.
  function automatic logic [6:0] byte_addr(input kind_t kind, input logic [3:0] word,
                                           input logic [1:0] j);
    logic [6:0] a;
    begin
      if (kind == KIND_PVT) begin
        if (word == PVT_PACKED_WORD) begin
          a = (j == 2'd0) ? 7'd20 : 7'd23;
        end else begin
          a = pvt_offset(word) + {5'd0, j};
        end
      end else begin
        a = {5'd0, j};
      end
      return a;
    end
  endfunction

  function automatic logic [2:0] byte_count(input kind_t kind, input logic [3:0] word);
    logic [2:0] n;
    begin
      if (kind == KIND_PVT && word != PVT_PACKED_WORD) begin
        n = 3'd4;
      end else begin
        n = 3'd2;
      end
      return n;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ubx_frame_parser_core.sv =====
// UBX frame parser top level: byte framing, Fletcher-8 check, result emission.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | in_tdata[7:0] rx_byte, in_tuser[0] op
//  out     | out | out_tvalid/out_tready| out_tdata word_index,value; out_tuser kind
//
// One received byte per cycle while no result is pending.
// After CK_B of a good frame the emitter owns the payload RAM port: ack/nak
// and other frames give one result word, NAV-PVT 13 words, each read from the RAM
// byte by byte (other frames excepted); in_tready stays low until the last beat is taken.
// Reset (rst_n low, synchronous) returns to sync search; the RAM is not cleared.
`default_nettype none
module ubx_frame_parser_core #(
  parameter int PAYLOAD_MAX = ubx_pkg::PAYLOAD_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [3:0] word_index, [35:4] value, [39:36] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast
);

  localparam int AW    = $clog2(PAYLOAD_MAX);
  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

  ubx_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       cka_r, cka_nxt;

  logic             busy;
  logic             beat;
  logic [7:0]       b;
  logic [7:0]       add_a;
  logic [15:0]      len_full;
  logic [CNT_W-1:0] cnt_inc;
  logic             wr_en;
  ubx_pkg::emit_req_t req;

  assign in_tready = !busy;
  assign beat      = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign add_a     = sum_a_r + b;
  assign len_full  = {b, len_r[7:0]};
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ubx_pkg::PH_SYNC1;
      class_r <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= '0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      cka_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      cka_r   <= cka_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    class_nxt     = class_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    cka_nxt       = cka_r;
    wr_en         = 1'b0;
    req.start     = 1'b0;
    req.kind      = ubx_pkg::KIND_OTHER;
    req.other_val = {id_r, class_r};
    if (class_r == ubx_pkg::CLS_ACK && len_r == ubx_pkg::ACK_LEN) begin
      req.kind = (id_r == ubx_pkg::ID_ACKOK) ? ubx_pkg::KIND_ACK : ubx_pkg::KIND_NAK;
    end else if (class_r == ubx_pkg::CLS_NAV && id_r == ubx_pkg::ID_PVT &&
                 len_r >= ubx_pkg::PVT_LEN) begin
      req.kind = ubx_pkg::KIND_PVT;
    end
    if (beat) begin
      if (in_tuser[0]) begin
        phase_nxt = ubx_pkg::PH_SYNC1;
      end else begin
        unique case (phase_r)
          ubx_pkg::PH_SYNC1: begin
            if (b == ubx_pkg::SYNC_FIRST) begin
              phase_nxt = ubx_pkg::PH_SYNC2;
            end
          end
          ubx_pkg::PH_SYNC2: begin
            phase_nxt = (b == ubx_pkg::SYNC_SECOND) ? ubx_pkg::PH_CLASS : ubx_pkg::PH_SYNC1;
          end
          ubx_pkg::PH_CLASS: begin
            class_nxt = b;
            sum_a_nxt = b;
            sum_b_nxt = b;
            phase_nxt = ubx_pkg::PH_ID;
          end
          ubx_pkg::PH_ID: begin
            id_nxt    = b;
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            phase_nxt = ubx_pkg::PH_LEN1;
          end
          ubx_pkg::PH_LEN1: begin
            len_nxt   = {8'd0, b};
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            phase_nxt = ubx_pkg::PH_LEN2;
          end
          ubx_pkg::PH_LEN2: begin
            len_nxt   = len_full;
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            cnt_nxt   = '0;
            if (len_full > 16'(PAYLOAD_MAX)) begin
              phase_nxt = ubx_pkg::PH_SYNC1;
            end else if (len_full == 16'd0) begin
              phase_nxt = ubx_pkg::PH_CKA;
            end else begin
              phase_nxt = ubx_pkg::PH_PAYLOAD;
            end
          end
          ubx_pkg::PH_PAYLOAD: begin
            wr_en     = 1'b1;
            cnt_nxt   = cnt_inc;
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            if (16'(cnt_inc) >= len_r) begin
              phase_nxt = ubx_pkg::PH_CKA;
            end
          end
          ubx_pkg::PH_CKA: begin
            cka_nxt   = b;
            phase_nxt = ubx_pkg::PH_CKB;
          end
          ubx_pkg::PH_CKB: begin
            req.start = (cka_r == sum_a_r) && (b == sum_b_r);
            phase_nxt = ubx_pkg::PH_SYNC1;
          end
          default: phase_nxt = ubx_pkg::PH_SYNC1;
        endcase
      end
    end
  end

  ubx_emitter #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .AW          (AW)
  ) u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (AW'(cnt_r)),
    .wr_data    (b),
    .req        (req),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/ubx_emitter.sv =====
// Payload store and result sequencer: reads stored bytes (or takes class/ID) and builds result beats.
`default_nettype none
`include "ubx_frame_parser_core_macros.svh"
module ubx_emitter #(
  parameter int PAYLOAD_MAX = ubx_pkg::PAYLOAD_MAX_DEF,
  parameter int AW          = $clog2(PAYLOAD_MAX)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire ubx_pkg::emit_req_t req,
  output logic                   busy,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  logic [7:0] mem [PAYLOAD_MAX];
  logic [7:0] rdata_r;

  ubx_pkg::emit_state_t state_r, state_nxt;
  ubx_pkg::kind_t       kind_r, kind_nxt;
  logic [3:0]           word_r, word_nxt;
  logic [2:0]           j_r, j_nxt;
  logic [31:0]          val_r, val_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [2:0]    nbytes;
  logic [1:0]    lane;
  logic          is_last;
  logic          out_fire;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign nbytes   = ubx_pkg::byte_count(kind_r, word_r);
  assign lane     = 2'(j_r - 3'd1);
  assign rd_addr  = AW'(ubx_pkg::byte_addr(kind_r, word_r, j_r[1:0]));
  assign rd_en    = (state_r == ubx_pkg::EM_FETCH) && (j_r < nbytes);
  assign is_last  = (kind_r != ubx_pkg::KIND_PVT) || (word_r == ubx_pkg::PVT_LAST_WORD);
  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ubx_pkg::EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
    word_r <= word_nxt;
    j_r    <= j_nxt;
    val_r  <= val_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    word_nxt  = word_r;
    j_nxt     = j_r;
    val_nxt   = val_r;
    unique case (state_r)
      ubx_pkg::EM_IDLE: begin
        if (req.start) begin
          kind_nxt = req.kind;
          word_nxt = 4'd0;
          j_nxt    = 3'd0;
          if (req.kind == ubx_pkg::KIND_OTHER) begin
            val_nxt   = {16'd0, req.other_val};
            state_nxt = ubx_pkg::EM_OUT;
          end else begin
            val_nxt   = 32'd0;
            state_nxt = ubx_pkg::EM_FETCH;
          end
        end
      end
      ubx_pkg::EM_FETCH: begin
        if (j_r != 3'd0) begin
          val_nxt[{lane, 3'b000} +: 8] = rdata_r;
        end
        if (j_r == nbytes) begin
          state_nxt = ubx_pkg::EM_OUT;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      ubx_pkg::EM_OUT: begin
        if (out_fire) begin
          if (is_last) begin
            state_nxt = ubx_pkg::EM_IDLE;
          end else begin
            word_nxt  = word_r + 4'd1;
            j_nxt     = 3'd0;
            val_nxt   = 32'd0;
            state_nxt = ubx_pkg::EM_FETCH;
          end
        end
      end
      default: state_nxt = ubx_pkg::EM_IDLE;
    endcase
  end

  assign busy       = (state_r != ubx_pkg::EM_IDLE);
  assign out_tvalid = (state_r == ubx_pkg::EM_OUT);
  assign out_tdata  = {4'd0, val_r, word_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = is_last;

  `UBX_ASSERT_IMP(a_start_idle, clk, rst_n, req.start, !busy, "frame start while emitting")
  `UBX_ASSERT_IMP(a_wr_idle, clk, rst_n, wr_en, !busy, "payload write during emission")
  `UBX_ASSERT_IMP(a_word_range, clk, rst_n, out_tvalid, word_r <= ubx_pkg::PVT_LAST_WORD,
                  "result word index out of range")
  `UBX_ASSERT_NXT(a_last_idle, clk, rst_n, out_fire && out_tlast, !busy,
                  "emitter not idle after last beat")

endmodule
`default_nettype wire
